>>> design/tcc_pkg.sv
// Shared types and constants for the text console cursor controller.
// No dependencies; every other design file refers to this package by scoped names.
package tcc_pkg;

  // Default values for the top-level parameters.
  localparam int TAB_STOP_DEF    = 4;
  localparam int COORD_WIDTH_DEF = 10;

  // Fixed field widths.
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CELL_W     = 10;
  localparam int CHAR_W     = 8;

  // Results per input transaction, and the width of the counter that tracks them.
  localparam int MAX_RESULTS = 5;
  localparam int RES_W       = 3;

  // Register reset values.
  localparam logic [CFG_W-1:0] COLUMNS_RST = CFG_W'(80);
  localparam logic [CFG_W-1:0] ROWS_RST    = CFG_W'(25);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd2;

  // Control characters with special handling.
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Input transaction kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_MOVE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Output actions.
  localparam logic [1:0] ACT_DRAW   = 2'd0;
  localparam logic [1:0] ACT_SCROLL = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_code;
    logic [CELL_W-1:0] new_col;
    logic [CELL_W-1:0] new_row;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]        action;
    logic [CELL_W-1:0] cell_col;
    logic [CELL_W-1:0] cell_row;
    logic [CHAR_W-1:0] glyph_code;
    logic              last;
  } out_item_t;

  // Decoded class of the held input transaction.
  typedef enum logic [2:0] {
    CLS_IGNORE,
    CLS_MOVE,
    CLS_CLEAR,
    CLS_NEWLINE,
    CLS_CR,
    CLS_BS,
    CLS_TAB,
    CLS_PRINT
  } cls_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MOVE,
    OP_CLEAR,
    OP_NEXT_LINE,
    OP_CR,
    OP_BS,
    OP_TAB_START,
    OP_TAB_LOAD,
    OP_PRINT_LOAD,
    OP_DRAW,
    OP_FLUSH
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    op_t op;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cls_t cls;
    logic emit_ok;
    logic out_free;
    logic pend_valid;
    logic wrap_need;
    logic wrap_fits;
    logic res_full;
    logic spaces_last;
    logic rem_done;
  } status_t;

endpackage

>>> design/text_console_cursor_controller.sv
// Top level of the text console cursor controller.
// Depends on tcc_pkg; instantiates tcc_ctrl and tcc_datapath.
//
//   Port group  Direction  Handshake          Payload
//   in_         input      in_valid/in_stall  tcc_pkg::in_item_t
//   out_        output     out_valid/out_stall tcc_pkg::out_item_t
//   cfg_        input      cfg_we             cfg_index, cfg_wdata
//
// One transaction is handled at a time. A printable character is accepted, dispatched,
// checked for a wrap, drawn and finished; newline, carriage return, backspace, clear and
// cursor moves go from dispatch straight to finish. A tab first waits on the two-stage
// column remainder unit, then checks and draws once per space until the expansion ends
// or stops early. Results leave at most one per cycle through an output register; a
// stalled output holds the sequencer. Reset is synchronous and needs no clearing pass.
module text_console_cursor_controller #(
  parameter int TAB_STOP    = tcc_pkg::TAB_STOP_DEF,
  parameter int COORD_WIDTH = tcc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tcc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tcc_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcc_pkg::CFG_W-1:0]     cfg_wdata
);

  tcc_pkg::cmd_t    cmd;
  tcc_pkg::status_t status;

  // Sequencer.
  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Cursor and result datapath.
  tcc_datapath #(
    .TAB_STOP    (TAB_STOP),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> design/tcc_tab_rem.sv
// Column remainder unit: cursor column modulo the tab stop, by reciprocal multiplication
// for the quotient, then subtraction. Depends on tcc_pkg for the parameter defaults.
module tcc_tab_rem #(
  parameter int TAB_STOP    = tcc_pkg::TAB_STOP_DEF,
  parameter int COORD_WIDTH = tcc_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COORD_WIDTH-1:0] col,
  output logic [COORD_WIDTH-1:0] rem,
  output logic                   done
);

  // Scaled reciprocal of the tab stop; the quotient is exact over the whole column range.
  localparam int SH    = COORD_WIDTH + $clog2(TAB_STOP);
  localparam int RECIP = ((1 << SH) + TAB_STOP - 1) / TAB_STOP;
  localparam int RCW   = COORD_WIDTH + 2;
  localparam int PW    = COORD_WIDTH + RCW;

  logic [COORD_WIDTH-1:0] col_r;
  logic [COORD_WIDTH-1:0] quot_r;
  logic [COORD_WIDTH-1:0] quot_nxt;
  logic [COORD_WIDTH-1:0] rem_r;
  logic [COORD_WIDTH-1:0] rem_nxt;
  logic [PW-1:0]          prod;
  logic                   busy_r;
  logic                   done_r;

  // First stage: quotient from the reciprocal product.
  assign prod     = PW'(col) * PW'(RECIP);
  assign quot_nxt = COORD_WIDTH'(prod >> SH);

  // Second stage: remainder from the quotient.
  assign rem_nxt  = col_r - (quot_r * COORD_WIDTH'(TAB_STOP));

  // Stage sequencing: the start is registered as busy, and busy in turn as done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (start) begin
      col_r  <= col;
      quot_r <= quot_nxt;
    end
    if (busy_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

>>> design/tcc_datapath.sv
// Datapath: configuration registers, cursor, held transaction, result staging and output register.
// Depends on tcc_pkg and instantiates tcc_tab_rem.
module tcc_datapath #(
  parameter int TAB_STOP    = tcc_pkg::TAB_STOP_DEF,
  parameter int COORD_WIDTH = tcc_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcc_pkg::CFG_W-1:0]      cfg_wdata,
  input  tcc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tcc_pkg::out_item_t             out_data,
  input  tcc_pkg::cmd_t                  cmd,
  output tcc_pkg::status_t               status
);

  localparam int CW   = COORD_WIDTH;
  localparam int CFW  = tcc_pkg::CFG_W;
  localparam int CMPW = ((CW > CFW) ? CW : CFW) + 1;
  localparam int SPW  = $clog2(TAB_STOP + 1);
  localparam int RW   = tcc_pkg::RES_W;

  // Configuration.
  logic           enabled_r;
  logic [CFW-1:0] columns_r;
  logic [CFW-1:0] rows_r;

  // Cursor and per-transaction state.
  logic [CW-1:0]             col_r;
  logic [CW-1:0]             row_r;
  tcc_pkg::in_item_t         item_r;
  logic [tcc_pkg::CHAR_W-1:0] glyph_r;
  logic [SPW-1:0]            spaces_r;
  logic [RW-1:0]             res_r;

  // One result is held back until it is known whether another follows.
  logic                      pend_valid_r;
  tcc_pkg::out_item_t        pend_r;
  logic                      out_valid_r;
  tcc_pkg::out_item_t        out_r;

  // Derived values.
  logic [CMPW-1:0]           col_ext;
  logic [CMPW-1:0]           row_inc_ext;
  logic                      wrap_need;
  logic                      scroll_need;
  logic [CW-1:0]             row_scrolled;
  logic [CW-1:0]             row_inc;
  logic [CW-1:0]             col_dec;
  logic                      wrap_fits;
  logic                      out_free;
  logic                      push;
  logic                      emit_en;
  tcc_pkg::out_item_t        emit_res;
  tcc_pkg::out_item_t        push_res;
  tcc_pkg::cls_t             cls;
  logic [CW-1:0]             rem;
  logic                      rem_done;
  logic                      rem_start;

  // Tab column remainder unit.
  assign rem_start = (cmd.op == tcc_pkg::OP_TAB_START);

  tcc_tab_rem #(
    .TAB_STOP    (TAB_STOP),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_tab_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .col   (col_r),
    .rem   (rem),
    .done  (rem_done)
  );

  // Edge tests against the screen size, at a width that holds both sides.
  assign col_ext      = CMPW'(col_r);
  assign row_inc_ext  = CMPW'(row_r) + CMPW'(1);
  assign wrap_need    = (col_ext >= CMPW'(columns_r));
  assign scroll_need  = (row_inc_ext >= CMPW'(rows_r));
  assign row_scrolled = (rows_r == '0) ? '0 : CW'(rows_r - CFW'(1));
  assign row_inc      = row_r + CW'(1);
  assign col_dec      = col_r - CW'(1);
  assign wrap_fits    = ((RW + 1)'(res_r) + (scroll_need ? (RW + 1)'(2) : (RW + 1)'(1)))
                        <= (RW + 1)'(tcc_pkg::MAX_RESULTS);

  // Decode the held transaction.
  always_comb begin
    cls = tcc_pkg::CLS_IGNORE;
    if (item_r.kind == tcc_pkg::KIND_MOVE) begin
      cls = tcc_pkg::CLS_MOVE;
    end else if (item_r.kind == tcc_pkg::KIND_CLEAR && enabled_r) begin
      cls = tcc_pkg::CLS_CLEAR;
    end else if (item_r.kind == tcc_pkg::KIND_CHAR && enabled_r) begin
      if (item_r.char_code == tcc_pkg::CHAR_LF) begin
        cls = tcc_pkg::CLS_NEWLINE;
      end else if (item_r.char_code == tcc_pkg::CHAR_CR) begin
        cls = tcc_pkg::CLS_CR;
      end else if (item_r.char_code == tcc_pkg::CHAR_TAB) begin
        cls = tcc_pkg::CLS_TAB;
      end else if (item_r.char_code == tcc_pkg::CHAR_BS) begin
        cls = tcc_pkg::CLS_BS;
      end else begin
        cls = tcc_pkg::CLS_PRINT;
      end
    end
  end

  // Result produced by the current operation, if any.
  always_comb begin
    emit_en  = 1'b0;
    emit_res = '0;
    unique case (cmd.op)
      tcc_pkg::OP_CLEAR: begin
        emit_en         = 1'b1;
        emit_res.action = tcc_pkg::ACT_CLEAR;
      end
      tcc_pkg::OP_NEXT_LINE: begin
        emit_en         = scroll_need;
        emit_res.action = tcc_pkg::ACT_SCROLL;
      end
      tcc_pkg::OP_BS: begin
        emit_en             = (col_r != '0);
        emit_res.action     = tcc_pkg::ACT_DRAW;
        emit_res.cell_col   = tcc_pkg::CELL_W'(col_dec);
        emit_res.cell_row   = tcc_pkg::CELL_W'(row_r);
        emit_res.glyph_code = tcc_pkg::CHAR_SPACE;
      end
      tcc_pkg::OP_DRAW: begin
        emit_en             = 1'b1;
        emit_res.action     = tcc_pkg::ACT_DRAW;
        emit_res.cell_col   = tcc_pkg::CELL_W'(col_r);
        emit_res.cell_row   = tcc_pkg::CELL_W'(row_r);
        emit_res.glyph_code = glyph_r;
      end
      default: begin
        emit_en  = 1'b0;
        emit_res = '0;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign push     = (emit_en && pend_valid_r) || (cmd.op == tcc_pkg::OP_FLUSH);

  // The held result on its way out; only the flush marks it as the last one.
  always_comb begin
    push_res      = pend_r;
    push_res.last = (cmd.op == tcc_pkg::OP_FLUSH);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      columns_r <= tcc_pkg::COLUMNS_RST;
      rows_r    <= tcc_pkg::ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcc_pkg::REG_ENABLED: enabled_r <= cfg_wdata[0];
        tcc_pkg::REG_COLUMNS: columns_r <= cfg_wdata;
        tcc_pkg::REG_ROWS:    rows_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Cursor, counters and result staging.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      res_r        <= '0;
      spaces_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      unique case (cmd.op)
        tcc_pkg::OP_ACCEPT: begin
          res_r <= '0;
        end
        tcc_pkg::OP_MOVE: begin
          if (item_r.new_col < columns_r) begin
            col_r <= CW'(item_r.new_col);
          end
          if (item_r.new_row < rows_r) begin
            row_r <= CW'(item_r.new_row);
          end
        end
        tcc_pkg::OP_CLEAR: begin
          col_r <= '0;
          row_r <= '0;
        end
        tcc_pkg::OP_NEXT_LINE: begin
          col_r <= '0;
          row_r <= scroll_need ? row_scrolled : row_inc;
        end
        tcc_pkg::OP_CR: begin
          col_r <= '0;
        end
        tcc_pkg::OP_BS: begin
          if (col_r != '0) begin
            col_r <= col_dec;
          end
        end
        tcc_pkg::OP_TAB_LOAD: begin
          spaces_r <= SPW'(TAB_STOP) - SPW'(rem);
        end
        tcc_pkg::OP_PRINT_LOAD: begin
          spaces_r <= SPW'(1);
        end
        tcc_pkg::OP_DRAW: begin
          col_r    <= col_r + CW'(1);
          spaces_r <= spaces_r - SPW'(1);
        end
        default: ;
      endcase

      // A new result displaces the held one towards the output.
      if (emit_en) begin
        pend_valid_r <= 1'b1;
        res_r        <= res_r + RW'(1);
      end else if (cmd.op == tcc_pkg::OP_FLUSH) begin
        pend_valid_r <= 1'b0;
      end

      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.op == tcc_pkg::OP_ACCEPT) begin
      item_r <= in_data;
    end
    if (cmd.op == tcc_pkg::OP_TAB_START) begin
      glyph_r <= tcc_pkg::CHAR_SPACE;
    end else if (cmd.op == tcc_pkg::OP_PRINT_LOAD) begin
      glyph_r <= item_r.char_code;
    end
    if (emit_en) begin
      pend_r <= emit_res;
    end
    if (push) begin
      out_r <= push_res;
    end
  end

  // Status towards the controller.
  always_comb begin
    status             = '0;
    status.cls         = cls;
    status.emit_ok     = !pend_valid_r || out_free;
    status.out_free    = out_free;
    status.pend_valid  = pend_valid_r;
    status.wrap_need   = wrap_need;
    status.wrap_fits   = wrap_fits;
    status.res_full    = (res_r >= RW'(tcc_pkg::MAX_RESULTS));
    status.spaces_last = (spaces_r == SPW'(1));
    status.rem_done    = rem_done;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/tcc_ctrl.sv
// Controller state machine: sequences one input transaction through the datapath.
// Depends on tcc_pkg for the command and status types.
module tcc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output tcc_pkg::cmd_t    cmd,
  input  tcc_pkg::status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_TAB_REM,
    S_CHECK,
    S_DRAW,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;

  // Next state and the operation issued this cycle.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = tcc_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = tcc_pkg::OP_ACCEPT;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        unique case (status.cls)
          tcc_pkg::CLS_MOVE:    cmd.op = tcc_pkg::OP_MOVE;
          tcc_pkg::CLS_CLEAR:   cmd.op = tcc_pkg::OP_CLEAR;
          tcc_pkg::CLS_NEWLINE: cmd.op = tcc_pkg::OP_NEXT_LINE;
          tcc_pkg::CLS_CR:      cmd.op = tcc_pkg::OP_CR;
          tcc_pkg::CLS_BS:      cmd.op = tcc_pkg::OP_BS;
          tcc_pkg::CLS_TAB: begin
            cmd.op    = tcc_pkg::OP_TAB_START;
            state_nxt = S_TAB_REM;
          end
          tcc_pkg::CLS_PRINT: begin
            cmd.op    = tcc_pkg::OP_PRINT_LOAD;
            state_nxt = S_CHECK;
          end
          default: cmd.op = tcc_pkg::OP_NONE;
        endcase
      end
      S_TAB_REM: begin
        if (status.rem_done) begin
          cmd.op    = tcc_pkg::OP_TAB_LOAD;
          state_nxt = S_CHECK;
        end
      end
      // Wrap to a new line first if the cursor is at the right edge, as long as
      // the wrap and the glyph both still fit in this transaction's results.
      S_CHECK: begin
        priority if (status.wrap_need) begin
          if (!status.wrap_fits) begin
            state_nxt = S_FINISH;
          end else if (status.emit_ok) begin
            cmd.op    = tcc_pkg::OP_NEXT_LINE;
            state_nxt = S_DRAW;
          end
        end else if (status.res_full) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        if (status.emit_ok) begin
          cmd.op    = tcc_pkg::OP_DRAW;
          state_nxt = status.spaces_last ? S_FINISH : S_CHECK;
        end
      end
      // Release the held result, marked as the last of the transaction.
      S_FINISH: begin
        if (!status.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          cmd.op    = tcc_pkg::OP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

>>> design/tcc_checker.sv
// Port-level checks for the text console cursor controller, bound to the top level.
// Depends on tcc_pkg for the result payload type.
module tcc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tcc_pkg::out_item_t out_data
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result payload changed while stalled");

  // Only one input transaction is in the block at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after an acceptance");

  // A clear is the only result of its transaction.
  a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == tcc_pkg::ACT_CLEAR |-> out_data.last)
    else $error("clear result not marked last");

  // Scroll and clear results carry no cell or glyph.
  a_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.action == tcc_pkg::ACT_SCROLL ||
                  out_data.action == tcc_pkg::ACT_CLEAR)
    |-> out_data.cell_col == '0 && out_data.cell_row == '0 && out_data.glyph_code == '0)
    else $error("non-draw result carries cell data");

endmodule

bind text_console_cursor_controller tcc_checker u_tcc_checker (.*);

>>> tb/tcc_command_checker.sv
// Checker for the text console cursor controller: watches the input, result and
// configuration ports, predicts the screen commands and compares them in order.
// Depends on tcc_pkg for the transaction types, codes and limits.
module tcc_command_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  tcc_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  tcc_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int TAB_SPACING = TAB_STOP_DEF;
  localparam int SHOWN_LIMIT = 10;

  // Shadow of the configuration registers and the cursor.
  logic              en_q     = 1'b1;
  logic [CFG_W-1:0]  cols_q   = COLUMNS_RST;
  logic [CFG_W-1:0]  rows_q   = ROWS_RST;
  logic [CELL_W-1:0] cur_col  = '0;
  logic [CELL_W-1:0] cur_row  = '0;

  // Commands still owed by the block, oldest first, and those of the current transaction.
  out_item_t expected_cmds[$];
  out_item_t item_cmds[$];

  int errors  = 0;
  int waiting = 0;
  int checked = 0;

  assign fail_count   = errors;
  assign pending      = waiting;
  assign results_seen = checked;

  // Appends one command unless the transaction already has its maximum.
  function automatic bit push_cmd(logic [1:0] act, logic [CELL_W-1:0] col,
                                  logic [CELL_W-1:0] row, logic [CHAR_W-1:0] glyph);
    out_item_t c;
    if (item_cmds.size() >= MAX_RESULTS) return 1'b0;
    c.action     = act;
    c.cell_col   = col;
    c.cell_row   = row;
    c.glyph_code = glyph;
    c.last       = 1'b0;
    item_cmds.push_back(c);
    return 1'b1;
  endfunction

  // Moves to column 0 of the next row, scrolling when that row is off the screen.
  function automatic bit advance_line();
    int r;
    r = int'(cur_row) + 1;
    cur_col = '0;
    if (r >= int'(rows_q)) begin
      if (!push_cmd(ACT_SCROLL, '0, '0, '0)) return 1'b0;
      r = (rows_q == '0) ? 0 : int'(rows_q) - 1;
    end
    cur_row = CELL_W'(r);
    return 1'b1;
  endfunction

  // Draws one glyph, wrapping first at the right edge; refuses if the commands would not fit.
  function automatic bit put_glyph(logic [CHAR_W-1:0] ch);
    int need;
    if (int'(cur_col) >= int'(cols_q)) begin
      need = (int'(cur_row) + 1 >= int'(rows_q)) ? 2 : 1;
      if (item_cmds.size() + need > MAX_RESULTS) return 1'b0;
      void'(advance_line());
    end else if (item_cmds.size() >= MAX_RESULTS) begin
      return 1'b0;
    end
    void'(push_cmd(ACT_DRAW, cur_col, cur_row, ch));
    cur_col = cur_col + 1'b1;
    return 1'b1;
  endfunction

  // Works out the commands caused by one accepted transaction and queues them.
  function automatic void predict_commands(in_item_t t);
    int spaces;
    item_cmds.delete();
    case (t.kind)
      KIND_MOVE: begin
        // Each coordinate is taken only when it lies on the screen; not gated by enable.
        if (t.new_col < cols_q) cur_col = t.new_col;
        if (t.new_row < rows_q) cur_row = t.new_row;
      end
      KIND_CLEAR: begin
        if (en_q) begin
          void'(push_cmd(ACT_CLEAR, '0, '0, '0));
          cur_col = '0;
          cur_row = '0;
        end
      end
      KIND_CHAR: begin
        if (en_q) begin
          case (t.char_code)
            CHAR_LF: void'(advance_line());
            CHAR_CR: cur_col = '0;
            CHAR_TAB: begin
              // Spaces up to the next tab stop; expansion stops when the commands run out.
              spaces = TAB_SPACING - (int'(cur_col) % TAB_SPACING);
              for (int i = 0; i < spaces; i++) begin
                if (!put_glyph(CHAR_SPACE)) break;
              end
            end
            CHAR_BS: begin
              if (cur_col != '0) begin
                cur_col = cur_col - 1'b1;
                void'(push_cmd(ACT_DRAW, cur_col, cur_row, CHAR_SPACE));
              end
            end
            default: void'(put_glyph(t.char_code));
          endcase
        end
      end
      default: ;
    endcase
    if (item_cmds.size() > 0) item_cmds[item_cmds.size()-1].last = 1'b1;
    foreach (item_cmds[i]) expected_cmds.push_back(item_cmds[i]);
  endfunction

  // Counts a failure and reports it while the report limit allows.
  function automatic void note_failure(string msg);
    errors++;
    if (errors <= SHOWN_LIMIT) $display("[%0t] %s", $time, msg);
  endfunction

  // Register writes, then input transactions, then result transactions, all at the edge.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      en_q    = 1'b1;
      cols_q  = COLUMNS_RST;
      rows_q  = ROWS_RST;
      cur_col = '0;
      cur_row = '0;
      expected_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED: en_q   = cfg_wdata[0];
          REG_COLUMNS: cols_q = cfg_wdata;
          REG_ROWS:    rows_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_commands(in_data);
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_cmds.size() == 0) begin
          note_failure($sformatf("Command with none expected: act=%0d col=%0d row=%0d glyph=%02h last=%0d",
                                 out_data.action, out_data.cell_col, out_data.cell_row,
                                 out_data.glyph_code, out_data.last));
        end else begin
          want = expected_cmds.pop_front();
          if (out_data.action !== want.action || out_data.cell_col !== want.cell_col ||
              out_data.cell_row !== want.cell_row || out_data.glyph_code !== want.glyph_code ||
              out_data.last !== want.last) begin
            note_failure($sformatf({"Command %0d differs: expected act=%0d col=%0d row=%0d ",
                                    "glyph=%02h last=%0d, got act=%0d col=%0d row=%0d ",
                                    "glyph=%02h last=%0d"},
                                   checked, want.action, want.cell_col, want.cell_row,
                                   want.glyph_code, want.last, out_data.action,
                                   out_data.cell_col, out_data.cell_row, out_data.glyph_code,
                                   out_data.last));
          end
        end
      end
    end
    waiting = expected_cmds.size();
  end

endmodule

>>> tb/text_console_cursor_controller_tb.sv
// Testbench top for the text console cursor controller: clock, reset, stimulus,
// random idling on both channels and the final verdict.
// Depends on tcc_pkg, the design and tcc_command_checker.
module text_console_cursor_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 50;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_count;
  int pending;
  int results_seen;
  int cycles         = 0;
  int items_sent     = 0;
  int settings_used  = 1;

  // When set, neither side idles.
  bit calm = 1'b0;

  // Screen size in force, used to aim cursor moves.
  logic [CFG_W-1:0] scr_cols = COLUMNS_RST;
  logic [CFG_W-1:0] scr_rows = ROWS_RST;

  text_console_cursor_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tcc_command_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: a random stall before each command, none while calm.
  always @(posedge clk) begin : result_stall
    int unsigned hold;
    if (!rst_n) begin
      hold = 0;
    end else if (out_valid && !out_stall) begin
      hold = calm ? 0 : $urandom_range(0, 19);
    end else if (hold != 0) begin
      hold--;
    end
    out_stall <= (hold != 0);
  end

  function automatic in_item_t make_item(logic [1:0] k, logic [CHAR_W-1:0] c,
                                         logic [CELL_W-1:0] col, logic [CELL_W-1:0] row);
    in_item_t t;
    t.kind      = k;
    t.char_code = c;
    t.new_col   = col;
    t.new_row   = row;
    return t;
  endfunction

  // Character transaction; the unused coordinates carry random noise.
  function automatic in_item_t chr(logic [CHAR_W-1:0] c);
    return make_item(KIND_CHAR, c, CELL_W'($urandom_range(0, 1023)),
                     CELL_W'($urandom_range(0, 1023)));
  endfunction

  // Cursor move; the unused character byte carries random noise.
  function automatic in_item_t move_to(int col, int row);
    return make_item(KIND_MOVE, CHAR_W'($urandom_range(0, 255)), CELL_W'(col), CELL_W'(row));
  endfunction

  // Random transaction, weighted towards control characters and moves near the edges.
  function automatic in_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 36) return chr(CHAR_W'($urandom_range(32, 126)));
    if (pick < 44) return chr(CHAR_W'($urandom_range(0, 255)));
    if (pick < 54) return chr(CHAR_LF);
    if (pick < 59) return chr(CHAR_CR);
    if (pick < 69) return chr(CHAR_TAB);
    if (pick < 77) return chr(CHAR_BS);
    if (pick < 83) return move_to($urandom_range(0, 1023), $urandom_range(0, 1023));
    if (pick < 93) return move_to($urandom_range(0, scr_cols), $urandom_range(0, scr_rows));
    if (pick < 98) return make_item(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                    CELL_W'($urandom_range(0, 1023)),
                                    CELL_W'($urandom_range(0, 1023)));
    return make_item(2'd3, CHAR_W'($urandom_range(0, 255)), CELL_W'($urandom_range(0, 1023)),
                     CELL_W'($urandom_range(0, 1023)));
  endfunction

  // Offers one transaction after a random gap and returns at the edge that takes it.
  task automatic send(in_item_t t);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Holds off until every expected command is back and any silent work has finished.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges once the block is idle.
  task automatic set_screen(bit en, int cols, int rows);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENABLED;
    cfg_wdata <= CFG_W'(en);
    @(posedge clk);
    cfg_index <= REG_COLUMNS;
    cfg_wdata <= CFG_W'(cols);
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_wdata <= CFG_W'(rows);
    @(posedge clk);
    cfg_we    <= 1'b0;
    scr_cols  = CFG_W'(cols);
    scr_rows  = CFG_W'(rows);
    settings_used++;
  endtask

  // One random phase; halfway through the sender waits for every command to return.
  task automatic run_phase(bit en, int cols, int rows, int count, bit quiet);
    set_screen(en, cols, rows);
    calm = quiet;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      send(random_item());
    end
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ENABLED;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset screen: byte extremes, tabs from two columns, backspace, wrap and scroll.
    send(chr(8'h41));
    send(chr(8'h00));
    send(chr(8'hFF));
    send(chr(CHAR_TAB));
    send(chr(CHAR_TAB));
    send(chr(CHAR_BS));
    send(chr(CHAR_CR));
    send(chr(CHAR_BS));
    send(chr(CHAR_LF));
    send(move_to(79, 24));
    send(chr(8'h5A));
    send(chr(8'h59));
    send(chr(CHAR_LF));
    send(move_to(1023, 1023));
    send(move_to(80, 3));
    send(make_item(KIND_CLEAR, 8'h00, '0, '0));
    send(make_item(2'd3, 8'hFF, 10'h3FF, 10'h3FF));

    // Disabled: characters and clears are dropped, a cursor move still lands.
    set_screen(1'b0, 1023, 1023);
    send(chr(8'h71));
    send(make_item(KIND_CLEAR, 8'hFF, 10'h3FF, 10'h3FF));
    send(move_to(1000, 900));

    // Screen shrunk under the cursor: backspace and newline from beyond the edges.
    set_screen(1'b1, 10, 5);
    send(chr(CHAR_BS));
    send(chr(CHAR_LF));

    // One cell screen: a tab runs out of commands part way.
    set_screen(1'b1, 1, 1);
    send(chr(CHAR_TAB));

    // Zero columns and rows.
    set_screen(1'b1, 0, 0);
    send(chr(8'h70));
    send(chr(CHAR_LF));
    send(chr(CHAR_BS));

    // Random phases over typical, tiny, extreme and random screens, one of them disabled.
    run_phase(1'b1, 80, 25, PHASE_ITEMS, 1'b0);
    run_phase(1'b1, $urandom_range(1, 12), $urandom_range(1, 6), PHASE_ITEMS, 1'b1);
    run_phase(1'b1, 1, 1, PHASE_ITEMS, 1'b0);
    run_phase(1'b0, 1023, 1023, 25, 1'b0);
    run_phase(1'b1, 1023, 1023, PHASE_ITEMS, 1'b0);
    run_phase(1'b1, $urandom_range(1, 1023), $urandom_range(1, 1023), PHASE_ITEMS, 1'b0);
    run_phase(1'b1, $urandom_range(2, 9), $urandom_range(1, 4), PHASE_ITEMS, 1'b0);
    drain();

    $display("Run summary: %0d input transactions sent under %0d screen settings,",
             items_sent, settings_used);
    $display("%0d screen commands compared, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
